/* hw/rtl/dphash_pkg.sv */
package dphash_pkg;

	localparam int unsigned DataW   = 31;
	localparam int unsigned ChW     = 8;
	localparam int unsigned HashW   = 63;
	localparam int unsigned ProdW   = 2 * DataW;
	localparam int unsigned CntW    = $clog2(ProdW);
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned Lanes   = 2;

	localparam logic [DataW-1:0] ResetBaseA = DataW'(1949313259);
	localparam logic [DataW-1:0] ResetBaseB = DataW'(1997293877);
	localparam logic [DataW-1:0] ResetModA  = DataW'(2091573227);
	localparam logic [DataW-1:0] ResetModB  = DataW'(2117566807);

	typedef enum logic [CfgIdxW-1:0] {
		CfgBaseA = 2'd0,
		CfgBaseB = 2'd1,
		CfgModA  = 2'd2,
		CfgModB  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		StIdle,
		StMul,
		StRed,
		StDone
	} state_t;

	typedef struct packed {
		logic capture;
		logic start;
		logic step;
		logic commit;
	} ctrl_cmd_t;

endpackage

/* hw/rtl/dphash_in_if.sv */
interface dphash_in_if;
	import dphash_pkg::*;

	logic             valid;
	logic             ready;
	logic [ChW-1:0]   ch;
	logic             last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);

endinterface

/* hw/rtl/dphash_out_if.sv */
interface dphash_out_if;
	import dphash_pkg::*;

	logic             valid;
	logic             ready;
	logic [HashW-1:0] hash_value;
	logic             done_res;

	modport source (output valid, output hash_value, output done_res, input ready);
	modport sink (input valid, input hash_value, input done_res, output ready);

endinterface

/* hw/rtl/dphash_reducer.sv */
module dphash_reducer (
	input  logic                           clk,
	input  logic                           load,
	input  logic                           step,
	input  logic [dphash_pkg::ProdW-1:0]   value,
	input  logic [dphash_pkg::DataW-1:0]   modulus,
	output logic [dphash_pkg::DataW-1:0]   rem
);
	import dphash_pkg::*;

	logic [ProdW-1:0] dividend_q;
	logic [DataW-1:0] rem_q;
	logic [DataW:0]   trial;
	logic [DataW:0]   diff;
	logic             mod_small;

	// one restoring remainder step per cycle while step is high, msb first
	assign trial = {rem_q, dividend_q[ProdW-1]};
	assign diff  = trial - {1'b0, modulus};

	always_ff @(posedge clk) begin
		if (load) begin
			dividend_q <= value;
			rem_q      <= '0;
		end else if (step) begin
			dividend_q <= {dividend_q[ProdW-2:0], 1'b0};
			if (trial >= {1'b0, modulus}) begin
				rem_q <= diff[DataW-1:0];
			end else begin
				rem_q <= trial[DataW-1:0];
			end
		end
	end

	// modulus of zero or one gives zero
	assign mod_small = (modulus[DataW-1:1] == '0);
	assign rem       = mod_small ? '0 : rem_q;

endmodule

/* hw/rtl/dphash_ctrl.sv */
module dphash_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output dphash_pkg::ctrl_cmd_t   cmd
);
	import dphash_pkg::*;

	state_t          state_q;
	state_t          state_d;
	logic [CntW-1:0] cnt_q;
	logic            out_valid_q;
	logic            can_commit;
	logic            last_step;

	assign can_commit = !out_valid_q || out_ready;
	assign last_step  = (cnt_q == CntW'(ProdW - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			StIdle: begin
				if (in_valid) begin
					state_d = StMul;
				end
			end
			StMul: begin
				state_d = StRed;
			end
			StRed: begin
				if (last_step) begin
					state_d = StDone;
				end
			end
			StDone: begin
				if (can_commit) begin
					state_d = StIdle;
				end
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			StIdle: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			StMul: begin
				cmd.start = 1'b1;
			end
			StRed: begin
				cmd.step = 1'b1;
			end
			StDone: begin
				cmd.commit = can_commit;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/dphash_datapath.sv */
module dphash_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dphash_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [dphash_pkg::DataW-1:0]     cfg_data,
	input  logic [dphash_pkg::ChW-1:0]       ch,
	input  logic                             last,
	input  dphash_pkg::ctrl_cmd_t            cmd,
	output logic [dphash_pkg::HashW-1:0]     hash_value,
	output logic                             done_res
);
	import dphash_pkg::*;

	logic [DataW-1:0] base_q  [Lanes];
	logic [DataW-1:0] mod_q   [Lanes];
	logic [DataW-1:0] hash_q  [Lanes];
	logic [DataW-1:0] power_q [Lanes];
	logic [DataW-1:0] hash_red  [Lanes];
	logic [DataW-1:0] power_red [Lanes];
	logic [ChW-1:0]   ch_q;
	logic             last_q;
	logic [HashW-1:0] hash_value_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= ResetBaseA;
			base_q[1] <= ResetBaseB;
			mod_q[0]  <= ResetModA;
			mod_q[1]  <= ResetModB;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CfgBaseA: base_q[0] <= cfg_data;
				CfgBaseB: base_q[1] <= cfg_data;
				CfgModA:  mod_q[0]  <= cfg_data;
				CfgModB:  mod_q[1]  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q   <= ch;
			last_q <= last;
		end
		if (cmd.commit) begin
			hash_value_q <= {hash_red[0], 1'b0, hash_red[1]};
			done_q       <= last_q;
		end
	end

	for (genvar l = 0; l < Lanes; l++) begin : g_lane
		logic [ChW+DataW-1:0] char_prod;
		logic [ProdW-1:0]     sum;
		logic [ProdW-1:0]     pow_prod;

		assign char_prod = (ChW+DataW)'(ch_q) * (ChW+DataW)'(power_q[l]);
		assign sum       = ProdW'(char_prod) + ProdW'(hash_q[l]);
		assign pow_prod  = ProdW'(power_q[l]) * ProdW'(base_q[l]);

		dphash_reducer u_red_hash (
			.clk     (clk),
			.load    (cmd.start),
			.step    (cmd.step),
			.value   (sum),
			.modulus (mod_q[l]),
			.rem     (hash_red[l])
		);

		dphash_reducer u_red_power (
			.clk     (clk),
			.load    (cmd.start),
			.step    (cmd.step),
			.value   (pow_prod),
			.modulus (mod_q[l]),
			.rem     (power_red[l])
		);

		// string end returns the lane to hash zero, power one
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hash_q[l]  <= '0;
				power_q[l] <= DataW'(1);
			end else if (cmd.commit) begin
				if (last_q) begin
					hash_q[l]  <= '0;
					power_q[l] <= DataW'(1);
				end else begin
					hash_q[l]  <= hash_red[l];
					power_q[l] <= power_red[l];
				end
			end
		end
	end

	assign hash_value = hash_value_q;
	assign done_res   = done_q;

endmodule

/* hw/rtl/double_polynomial_string_hash_top.sv */
// channel    dir  fields                 transfer when
// char_in    in   ch[7:0], last          valid && ready
// hash_out   out  hash_value[62:0],      valid && ready
//                 done_res
// cfg        in   cfg_idx, cfg_data      cfg_we high
//
// each character passes through accept, a multiply state, the bit-serial
// remainder steps, one per product bit (four remainder units, hash and power
// for each lane, in parallel), and a commit, then back to idle
// the result sits in an output register, so the next character is taken
// while it waits; a second result waits in the commit state until it is taken
// reset clears the hashes to zero, powers to one and loads the default bases
// and moduli
module double_polynomial_string_hash_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dphash_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [dphash_pkg::DataW-1:0]     cfg_data,
	dphash_in_if.sink                        char_in,
	dphash_out_if.source                     hash_out
);
	import dphash_pkg::*;

	ctrl_cmd_t cmd;

	dphash_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (char_in.valid),
		.in_ready  (char_in.ready),
		.out_valid (hash_out.valid),
		.out_ready (hash_out.ready),
		.cmd       (cmd)
	);

	dphash_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.ch         (char_in.ch),
		.last       (char_in.last),
		.cmd        (cmd),
		.hash_value (hash_out.hash_value),
		.done_res   (hash_out.done_res)
	);

endmodule

/* test/tb.sv */
module tb;
	import dphash_pkg::*;

	localparam int CycleLimit = 1_500_000;
	localparam int DrainCycles = 70;
	localparam int HoldCycles = 400;
	localparam int PhaseChars = 425;
	localparam int DirRows = 36;

	typedef struct packed {
		logic [HashW-1:0] hash_value;
		logic             done_res;
	} hash_res_t;

	typedef struct {
		bit               is_write;
		cfg_idx_t         reg_idx;
		logic [DataW-1:0] reg_val;
		logic [ChW-1:0]   ch;
		logic             last;
		bit               pinned;
		logic [HashW-1:0] hash;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [DataW-1:0] cfg_data;

	dphash_in_if char_if();
	dphash_out_if hash_if();

	double_polynomial_string_hash_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.char_in  (char_if),
		.hash_out (hash_if)
	);

	// lane 0 is lane A, lane 1 is lane B
	logic [DataW-1:0] lane_hash [Lanes];
	logic [DataW-1:0] lane_power [Lanes];
	logic [DataW-1:0] lane_base [Lanes];
	logic [DataW-1:0] lane_mod [Lanes];

	hash_res_t pending_hashes [$];
	hash_res_t want;
	hash_res_t seen;

	// typed-in expectation travels with the character it belongs to
	logic pin_row;
	logic [HashW-1:0] pin_hash;

	int mismatches = 0;
	int chars_sent = 0;
	int strings_sent = 0;
	int reg_writes = 0;
	int holds_done = 0;
	int cycle_count = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	dir_row_t dir_rows [DirRows] = '{
		'{1'b0, CfgBaseA, '0, 8'd255, 1'b1, 1'b1, 63'h000000FF000000FF},
		'{1'b0, CfgBaseA, '0, 8'd0, 1'b1, 1'b1, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd1, 1'b0, 1'b1, 63'h0000000100000001},
		'{1'b0, CfgBaseA, '0, 8'd128, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd255, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd170, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd85, 1'b1, 1'b0, 63'h0},
		// moduli below two flatten both lanes
		'{1'b1, CfgModA, 31'd1, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgModB, 31'd0, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd200, 1'b1, 1'b1, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd255, 1'b0, 1'b1, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd7, 1'b1, 1'b1, 63'h0},
		'{1'b1, CfgModA, 31'd2, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgModB, 31'd2147483647, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgBaseA, 31'd0, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgBaseB, 31'd2147483646, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd255, 1'b0, 1'b1, 63'h00000001000000FF},
		'{1'b0, CfgBaseA, '0, 8'd255, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd255, 1'b1, 1'b0, 63'h0},
		// bases not below the modulus
		'{1'b1, CfgBaseA, 31'd9, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgBaseB, 31'd2147483647, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd3, 1'b0, 1'b1, 63'h0000000100000003},
		'{1'b0, CfgBaseA, '0, 8'd254, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd77, 1'b1, 1'b0, 63'h0},
		'{1'b1, CfgModA, ResetModA, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgModB, ResetModB, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgBaseA, ResetBaseA, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgBaseB, ResetBaseB, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd250, 1'b0, 1'b1, 63'h000000FA000000FA},
		'{1'b0, CfgBaseA, '0, 8'd131, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd66, 1'b0, 1'b0, 63'h0},
		// small moduli mid-string, held values above them
		'{1'b1, CfgModA, 31'd13, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b1, CfgModB, 31'd3, 8'd0, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd9, 1'b0, 1'b0, 63'h0},
		'{1'b0, CfgBaseA, '0, 8'd240, 1'b1, 1'b0, 63'h0}
	};

	function automatic logic [DataW-1:0] lane_residue(input logic [63:0] v,
			input logic [DataW-1:0] m);
		if (m < 31'd2)
			return '0;
		return DataW'(v % 64'(m));
	endfunction

	function automatic hash_res_t next_prefix_hash(input logic [ChW-1:0] c, input logic fin);
		hash_res_t r;
		logic [63:0] sum;
		for (int i = 0; i < Lanes; i++) begin
			sum = 64'(lane_hash[i]) + 64'(c) * 64'(lane_power[i]);
			lane_hash[i] = lane_residue(sum, lane_mod[i]);
			lane_power[i] = lane_residue(64'(lane_power[i]) * 64'(lane_base[i]), lane_mod[i]);
		end
		r.hash_value = {lane_hash[0], 1'b0, lane_hash[1]};
		r.done_res = fin;
		if (fin) begin
			for (int i = 0; i < Lanes; i++) begin
				lane_hash[i] = '0;
				lane_power[i] = 31'd1;
			end
		end
		return r;
	endfunction

	function automatic logic [DataW-1:0] pick_reg_value(input cfg_idx_t idx);
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(15))
			0: return '0;
			1: return 31'd1;
			2: return (idx == CfgModA || idx == CfgModB) ? 31'd2 : 31'd2147483646;
			3: return 31'd2147483647;
			4: return DataW'($urandom_range(2, 300));
			default: return raw[DataW-1:0];
		endcase
	endfunction

	function automatic logic [ChW-1:0] pick_char();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return ChW'($urandom_range(255));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// output side: random stalls, plus a long hold-off on request
	initial begin
		hash_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hash_if.ready <= 1'b0;
				hold_left--;
			end else begin
				hash_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_if.valid && char_if.ready) begin
				want = next_prefix_hash(char_if.ch, char_if.last);
				if (pin_row)
					want.hash_value = pin_hash;
				pending_hashes = {pending_hashes, want};
			end
			if (hash_if.valid && hash_if.ready) begin
				if (pending_hashes.size() == 0) begin
					mismatches++;
					$display("%0t unexpected transfer: expected none, got hash %h done %b",
						$time, hash_if.hash_value, hash_if.done_res);
				end else begin
					seen = pending_hashes.pop_front();
					if (hash_if.hash_value !== seen.hash_value) begin
						mismatches++;
						$display("%0t hash_value mismatch: expected %h, got %h",
							$time, seen.hash_value, hash_if.hash_value);
					end
					if (hash_if.done_res !== seen.done_res) begin
						mismatches++;
						$display("%0t done_res mismatch: expected %b, got %b",
							$time, seen.done_res, hash_if.done_res);
					end
				end
			end
		end
	end

	task automatic send_char(input logic [ChW-1:0] c, input logic fin, input bit pinned,
			input logic [HashW-1:0] pinned_hash);
		while ($urandom_range(99) < src_idle_pct) begin
			char_if.valid <= 1'b0;
			@(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.ch <= c;
		char_if.last <= fin;
		pin_row <= pinned;
		pin_hash <= pinned_hash;
		@(posedge clk);
		while (!char_if.ready)
			@(posedge clk);
		chars_sent++;
		if (fin)
			strings_sent++;
	endtask

	// stop offering, wait for every outstanding hash, then let the block settle
	task automatic quiesce();
		char_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgBaseA: lane_base[0] = val;
			CfgBaseB: lane_base[1] = val;
			CfgModA:  lane_mod[0] = val;
			CfgModB:  lane_mod[1] = val;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic write_random_regs();
		cfg_idx_t idx;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			if ($urandom_range(1))
				write_reg(idx, pick_reg_value(idx));
		end
	endtask

	task automatic run_strings(input int n_chars);
		int sent;
		int len;
		cfg_idx_t idx;
		sent = 0;
		while (sent < n_chars) begin
			if ($urandom_range(19) == 0) begin
				quiesce();
				write_random_regs();
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				if (k > 0 && $urandom_range(39) == 0) begin
					quiesce();
					idx = cfg_idx_t'($urandom_range(3));
					write_reg(idx, pick_reg_value(idx));
				end
				send_char(pick_char(), k == len - 1, 1'b0, '0);
			end
			sent += len;
		end
	endtask

	// long output stall while characters keep coming, so the input backs up
	task automatic stall_burst();
		hold_token <= hold_token + 1;
		holds_done++;
		for (int k = 0; k < 16; k++)
			send_char(pick_char(), k == 15, 1'b0, '0);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CfgBaseA;
		cfg_data <= '0;
		char_if.valid <= 1'b0;
		char_if.ch <= '0;
		char_if.last <= 1'b0;
		pin_row <= 1'b0;
		pin_hash <= '0;
		for (int i = 0; i < Lanes; i++) begin
			lane_hash[i] = '0;
			lane_power[i] = 31'd1;
		end
		lane_base[0] = ResetBaseA;
		lane_base[1] = ResetBaseB;
		lane_mod[0] = ResetModA;
		lane_mod[1] = ResetModB;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DirRows; r++) begin
			if (dir_rows[r].is_write) begin
				quiesce();
				write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
			end else begin
				send_char(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].pinned,
					dir_rows[r].hash);
			end
		end

		quiesce();
		src_idle_pct = 37;
		snk_idle_pct <= 87;
		write_reg(CfgBaseA, ResetBaseA);
		write_reg(CfgBaseB, ResetBaseB);
		write_reg(CfgModA, ResetModA);
		write_reg(CfgModB, ResetModB);
		stall_burst();
		run_strings(PhaseChars);

		quiesce();
		src_idle_pct = 87;
		snk_idle_pct <= 37;
		write_reg(CfgBaseA, 31'd2147483646);
		write_reg(CfgBaseB, 31'd1);
		write_reg(CfgModA, 31'd2147483647);
		write_reg(CfgModB, 31'd2147483647);
		run_strings(PhaseChars);

		quiesce();
		src_idle_pct = 0;
		snk_idle_pct <= 0;
		write_reg(CfgBaseA, pick_reg_value(CfgBaseA));
		write_reg(CfgBaseB, pick_reg_value(CfgBaseB));
		write_reg(CfgModA, pick_reg_value(CfgModA));
		write_reg(CfgModB, pick_reg_value(CfgModB));
		stall_burst();
		run_strings(PhaseChars);

		quiesce();
		$display("hashed %0d strings (%0d characters) over %0d register writes,",
			strings_sent, chars_sent, reg_writes);
		$display("three flow-control mixes and %0d long output hold-offs; %0d mismatches",
			holds_done, mismatches);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/dphash_pkg.sv
hw/rtl/dphash_in_if.sv
hw/rtl/dphash_out_if.sv
hw/rtl/dphash_reducer.sv
hw/rtl/dphash_ctrl.sv
hw/rtl/dphash_datapath.sv
hw/rtl/double_polynomial_string_hash_top.sv
test/tb.sv
